// File: hdl/rlc_pkg.sv
// ----------------------------------------------------------------------------
// rlc_pkg
// Shared types and constants of the raster 3x3 convolution block.
// ----------------------------------------------------------------------------
`default_nettype none
package rlc_pkg;

  localparam int unsigned PixW   = 16;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned RowW   = 48;
  localparam int unsigned GainW  = 32;
  localparam int unsigned LwW    = 11;
  localparam int unsigned CfgW   = 48;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SumW   = 38;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgUseReal = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGain    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTop     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMid     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBot     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLineW   = 3'd5;

  // window entry: value plus undefined flag
  typedef struct packed {
    logic            undef;
    logic [PixW-1:0] value;
  } pix_t;

  // one evaluation job handed from front to back
  typedef struct packed {
    pix_t [8:0] win;     // row-major, index r*3+c
    logic       force_undef;
    logic       last;
  } job_t;

  // one result item
  typedef struct packed {
    logic [31:0] filtered_value;
    logic        result_undefined;
    logic        last_of_run;
  } res_t;

endpackage
`default_nettype wire

// File: hdl/rlc_stream_if.sv
// ----------------------------------------------------------------------------
// rlc_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
`default_nettype none
interface rlc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/rlc_front.sv
// ----------------------------------------------------------------------------
// rlc_front
// Accepts pixels, keeps line buffers and the window, and emits up to two
// evaluation jobs per pixel into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none
module rlc_front #(
  parameter int unsigned LINE_WIDTH = 1024
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [rlc_pkg::PixW-1:0]  pixel_value_i,
  input  wire logic                      pixel_undefined_i,
  input  wire logic [rlc_pkg::LwW-1:0]   line_width_i,
  input  wire logic                      restart_i,
  output logic                           job_valid_o,
  input  wire logic                      job_ready_i,
  output rlc_pkg::job_t                  job_o
);
  import rlc_pkg::*;

  localparam int unsigned ColW = $clog2(LINE_WIDTH);

  typedef enum logic [1:0] {S_READ, S_SHIFT, S_SECOND} state_e;

  state_e            state_q;
  logic [ColW-1:0]   col_q;
  logic [1:0]        filled_q;
  pix_t [8:0]        win_q;
  pix_t              new_q;
  logic              pend_q;      // second job still to be sent
  logic [ColW:0]     wid;
  logic [ColW-1:0]   wlast;
  logic              col_last;
  logic              accept;

  // line memories, read data registered
  pix_t mem0 [LINE_WIDTH];
  pix_t mem1 [LINE_WIDTH];
  pix_t rd0_q, rd1_q;

  // effective width
  always_comb begin
    if (line_width_i == '0) wid = (ColW+1)'(1);
    else if (32'(line_width_i) > LINE_WIDTH) wid = (ColW+1)'(LINE_WIDTH);
    else wid = (ColW+1)'(line_width_i);
  end
  assign wlast    = ColW'(wid - 1'b1);
  assign col_last = (col_q >= wlast);

  assign in_ready_o = (state_q == S_READ) && !restart_i;
  assign accept     = in_valid_i && in_ready_o;

  // memory read/write at the current column
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd0_q <= mem0[col_q];
      rd1_q <= mem1[col_q];
      mem0[col_q] <= '{undef: pixel_undefined_i, value: pixel_value_i};
      mem1[col_q] <= mem0[col_q];
    end
  end

  // job generation from the window after the shift
  pix_t [8:0] nwin;
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nwin[r*3+0] = win_q[r*3+1];
      nwin[r*3+1] = win_q[r*3+2];
    end
    nwin[2] = (filled_q >= 2'd2) ? rd1_q : '{undef: 1'b1, value: '0};
    nwin[5] = (filled_q >= 2'd1) ? rd0_q : '{undef: 1'b1, value: '0};
    nwin[8] = new_q;
  end

  logic [ColW-1:0] jcol_q;   // column of the item being processed
  always_comb begin
    job_valid_o = 1'b0;
    job_o       = '0;
    if (state_q == S_SHIFT && jcol_q != '0) begin
      job_valid_o = 1'b1;
      job_o.win   = nwin;
      job_o.force_undef = (jcol_q == ColW'(1));  // left neighbor outside
      for (int r = 0; r < 3; r++) job_o.win[r*3+2] = nwin[r*3+2];
      job_o.last  = !pend_q;
    end else if (state_q == S_SECOND) begin
      job_valid_o = 1'b1;
      job_o.win   = win_q;
      job_o.force_undef = 1'b1;  // right neighbors outside
      job_o.last  = 1'b1;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_READ;
      col_q    <= '0;
      filled_q <= '0;
      pend_q   <= 1'b0;
      jcol_q   <= '0;
      for (int i = 0; i < 9; i++) win_q[i] <= '{undef: 1'b1, value: '0};
      new_q    <= '0;
    end else if (restart_i) begin
      state_q  <= S_READ;
      col_q    <= '0;
      filled_q <= '0;
      pend_q   <= 1'b0;
      for (int i = 0; i < 9; i++) win_q[i] <= '{undef: 1'b1, value: '0};
    end else begin
      case (state_q)
        S_READ: begin
          if (accept) begin
            new_q  <= '{undef: pixel_undefined_i, value: pixel_value_i};
            jcol_q <= col_q;
            pend_q <= col_last;
            if (col_last) begin
              col_q <= '0;
            end else begin
              col_q <= col_q + 1'b1;
            end
            state_q <= S_SHIFT;
          end
        end
        // the line count moves on only after the window has used it
        S_SHIFT: begin
          if (jcol_q == '0 || job_ready_i) begin
            win_q   <= nwin;
            if (pend_q && filled_q < 2'd2) filled_q <= filled_q + 2'd1;
            state_q <= pend_q ? S_SECOND : S_READ;
          end
        end
        S_SECOND: begin
          if (job_ready_i) begin
            pend_q  <= 1'b0;
            state_q <= S_READ;
          end
        end
        default: state_q <= S_READ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/rlc_queue.sv
// ----------------------------------------------------------------------------
// rlc_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module rlc_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire rlc_pkg::job_t  in_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rlc_pkg::job_t       out_o
);
  import rlc_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_o       = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: hdl/rlc_back.sv
// ----------------------------------------------------------------------------
// rlc_back
// Evaluates one job: nine products through one multiplier, scaling with split
// gain products or a rounded shift by eight, saturation, and a held result.
// ----------------------------------------------------------------------------
`default_nettype none
module rlc_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      job_valid_i,
  output logic                           job_ready_o,
  input  wire rlc_pkg::job_t             job_i,
  input  wire logic                      use_real_i,
  input  wire logic [rlc_pkg::GainW-1:0] gain_i,
  input  wire logic [rlc_pkg::RowW-1:0]  k_top_i,
  input  wire logic [rlc_pkg::RowW-1:0]  k_mid_i,
  input  wire logic [rlc_pkg::RowW-1:0]  k_bot_i,
  output logic                           res_valid_o,
  input  wire logic                      res_ready_i,
  output rlc_pkg::res_t                  res_o
);
  import rlc_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_MAC, B_HI, B_LO, B_FIN, B_OUT} state_e;

  state_e             state_q;
  job_t               job_q;
  logic [3:0]         idx_q;
  logic signed [SumW-1:0] sum_q;
  logic [SumW-1:0]    mag_q;
  logic               neg_q;
  logic [63:0]        acc_q;
  logic [53:0]        lo_q;
  logic               undef_q;

  // coefficient and pixel for the current tap
  logic [RowW-1:0]         krow;
  logic [1:0]              tcol;
  logic signed [CoefW-1:0] coef;
  pix_t                    px;
  logic signed [31:0]      prod;
  always_comb begin
    if (idx_q inside {[4'd0:4'd2]})      krow = k_top_i;
    else if (idx_q inside {[4'd3:4'd5]}) krow = k_mid_i;
    else                                 krow = k_bot_i;
    if (idx_q inside {4'd0, 4'd3, 4'd6})      tcol = 2'd0;
    else if (idx_q inside {4'd1, 4'd4, 4'd7}) tcol = 2'd1;
    else                                      tcol = 2'd2;
    coef = krow[tcol*CoefW +: CoefW];
    px   = job_q.win[idx_q];
    prod = $signed(px.value) * coef;
  end

  // saturation of final magnitude
  logic [31:0] fin;
  always_comb begin
    if (neg_q) fin = (acc_q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-acc_q);
    else       fin = (acc_q > 64'h7FFF_FFFF)  ? 32'h7FFF_FFFF : acc_q[31:0];
  end

  assign job_ready_o = (state_q == B_IDLE);
  assign res_valid_o = (state_q == B_OUT);

  // result item from the held job state
  assign res_o = '{filtered_value:   undef_q ? 32'd0 : fin,
                   result_undefined: undef_q,
                   last_of_run:      job_q.last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      idx_q   <= '0;
      undef_q <= 1'b0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            idx_q   <= '0;
            sum_q   <= '0;
            undef_q <= job_i.force_undef;
            state_q <= B_MAC;
          end
        end
        // one tap per cycle
        B_MAC: begin
          if (px.undef) undef_q <= 1'b1;
          sum_q <= sum_q + SumW'(prod);
          if (idx_q == 4'd8) state_q <= B_HI;
          else idx_q <= idx_q + 4'd1;
        end
        // magnitude and sign
        B_HI: begin
          neg_q <= sum_q[SumW-1];
          mag_q <= sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
          state_q <= B_LO;
        end
        B_LO: begin
          if (use_real_i) begin
            acc_q <= 64'((mag_q + SumW'(128)) >> 8);
          end else begin
            acc_q <= 64'(mag_q) * 64'(gain_i[31:16]);
            lo_q  <= 54'(mag_q) * 54'(gain_i[15:0]);
          end
          state_q <= B_FIN;
        end
        B_FIN: begin
          if (!use_real_i)
            acc_q <= acc_q + 64'((lo_q + 54'd32768) >> 16);
          state_q <= B_OUT;
        end
        B_OUT: begin
          if (res_ready_i) state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/raster_linear_convolution.sv
// ----------------------------------------------------------------------------
// raster_linear_convolution
// Streaming 3x3 convolution with two line buffers, Q16.16 gain or Q8.8 taps.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  pix_in   in   pixel_value, pixel_undefined
//  res_out  out  filtered_value, result_undefined, last_of_run
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i
// Each back-end job is taken, runs nine taps through one multiplier, then
// the magnitude, gain and rounding steps, and is handed off before the next.
// The front end reads the line memory and shifts the window for a pixel
// before it takes the next, and at a line end also sends a second job.
// Reset clears control state; line memories hold unknown data until written.
// A stalled output stops the back end; the queue then stops the front end.
`default_nettype none
module raster_linear_convolution #(
  parameter int unsigned LINE_WIDTH = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rlc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rlc_pkg::CfgW-1:0]     cfg_data_i,
  rlc_stream_if.sink                        pix_in,
  rlc_stream_if.source                      res_out
);
  import rlc_pkg::*;

  logic             use_real_q;
  logic [GainW-1:0] gain_q;
  logic [RowW-1:0]  ktop_q, kmid_q, kbot_q;
  logic [LwW-1:0]   lw_q;
  logic             restart;

  assign restart = cfg_we_i && (cfg_idx_i == CfgLineW);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_real_q <= 1'b0;
      gain_q     <= GainW'(65536);
      ktop_q     <= '0;
      kmid_q     <= RowW'(65536);
      kbot_q     <= '0;
      lw_q       <= LwW'(1024);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgUseReal: use_real_q <= cfg_data_i[0];
        CfgGain:    gain_q     <= cfg_data_i[GainW-1:0];
        CfgTop:     ktop_q     <= cfg_data_i;
        CfgMid:     kmid_q     <= cfg_data_i;
        CfgBot:     kbot_q     <= cfg_data_i;
        CfgLineW:   lw_q       <= cfg_data_i[LwW-1:0];
        default: ;
      endcase
    end
  end

  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj, bj;

  rlc_front #(.LINE_WIDTH(LINE_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i        (pix_in.valid),
    .in_ready_o        (pix_in.ready),
    .pixel_value_i     (pix_in.payload.value),
    .pixel_undefined_i (pix_in.payload.undef),
    .line_width_i      (lw_q),
    .restart_i         (restart),
    .job_valid_o       (fj_valid),
    .job_ready_i       (fj_ready),
    .job_o             (fj)
  );

  rlc_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i  (fj_valid), .in_ready_o (fj_ready), .in_i (fj),
    .out_valid_o (bj_valid), .out_ready_i (bj_ready), .out_o (bj)
  );

  rlc_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (bj_valid), .job_ready_o (bj_ready), .job_i (bj),
    .use_real_i  (use_real_q), .gain_i (gain_q),
    .k_top_i (ktop_q), .k_mid_i (kmid_q), .k_bot_i (kbot_q),
    .res_valid_o (res_out.valid),
    .res_ready_i (res_out.ready),
    .res_o       (res_out.payload)
  );

  // an undefined result carries zero
  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid && res_out.payload.result_undefined |->
      res_out.payload.filtered_value == '0)
    else $error("undefined result with nonzero value");

  // no pixel taken while a line width write restarts the raster
  a_no_accept_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart |-> !(pix_in.valid && pix_in.ready))
    else $error("pixel accepted during restart");
endmodule
`default_nettype wire
